// File: sv/sine_table_generator_16bit_defines.svh
// Assertion macros used by the checker file of the sine generator.
`ifndef SINE_TABLE_GENERATOR_16BIT_DEFINES_SVH
`define SINE_TABLE_GENERATOR_16BIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STG16_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STG16_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/stg16_pkg.sv
package stg16_pkg;

	localparam logic [31:0] PHASE_PI      = 32'h3243_F6A9;
	localparam logic [31:0] PHASE_HALF_PI = 32'h1921_FB54;
	localparam logic [15:0] INV6_U0F16    = 16'h2AAA;

	localparam int STEP_W = 4;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [1:0]        reg_idx_t;
	typedef logic [2:0]        op_t;
	typedef logic [2:0]        src_t;
	typedef logic [2:0]        dst_t;
	typedef logic [1:0]        cond_t;

	localparam reg_idx_t REG_OUTPUT_MODE = 2'd0;
	localparam reg_idx_t REG_PHASE_STEP  = 2'd1;
	localparam reg_idx_t REG_RANGE_MIN   = 2'd2;
	localparam reg_idx_t REG_RANGE_MAX   = 2'd3;

	localparam op_t OP_FOLD_PI   = 3'd0;
	localparam op_t OP_FOLD_HALF = 3'd1;
	localparam op_t OP_MUL       = 3'd2;
	localparam op_t OP_POLY      = 3'd3;
	localparam op_t OP_SCALE     = 3'd4;
	localparam op_t OP_EMIT      = 3'd5;

	localparam src_t SRC_X1   = 3'd0;
	localparam src_t SRC_X2   = 3'd1;
	localparam src_t SRC_X3   = 3'd2;
	localparam src_t SRC_X4   = 3'd3;
	localparam src_t SRC_INV6 = 3'd4;
	localparam src_t SRC_RES  = 3'd5;
	localparam src_t SRC_AMPL = 3'd6;

	localparam dst_t DST_X2 = 3'd0;
	localparam dst_t DST_X3 = 3'd1;
	localparam dst_t DST_T  = 3'd2;
	localparam dst_t DST_X4 = 3'd3;
	localparam dst_t DST_X5 = 3'd4;
	localparam dst_t DST_HI = 3'd5;

	localparam cond_t COND_NONE = 2'd0;
	localparam cond_t COND_RAW  = 2'd1;
	localparam cond_t COND_END  = 2'd2;

	localparam step_t STEP_EMIT = 4'd10;

	typedef struct packed {
		op_t   op;
		src_t  src_a;
		src_t  src_b;
		logic  shl;
		logic  sgn;
		dst_t  dst;
		cond_t cond;
		step_t target;
	} uop_t;

	function automatic uop_t mk_uop(input op_t op, input src_t src_a, input src_t src_b,
			input logic shl, input logic sgn, input dst_t dst, input cond_t cond,
			input step_t target);
		uop_t u;
		u.op     = op;
		u.src_a  = src_a;
		u.src_b  = src_b;
		u.shl    = shl;
		u.sgn    = sgn;
		u.dst    = dst;
		u.cond   = cond;
		u.target = target;
		return u;
	endfunction

	// The program: fold the phase, five chained multiplies for the polynomial,
	// then either emit the raw value or scale it with one more multiply.
	function automatic uop_t uop_rom(input step_t addr);
		uop_t u;
		case (addr)
			4'd0: u = mk_uop(OP_FOLD_PI, SRC_X1, SRC_X1, 1'b0, 1'b0, DST_X2, COND_NONE, '0);
			4'd1: u = mk_uop(OP_FOLD_HALF, SRC_X1, SRC_X1, 1'b0, 1'b0, DST_X2, COND_NONE, '0);
			4'd2: u = mk_uop(OP_MUL, SRC_X1, SRC_X1, 1'b0, 1'b0, DST_X2, COND_NONE, '0);
			4'd3: u = mk_uop(OP_MUL, SRC_X2, SRC_X1, 1'b1, 1'b0, DST_X3, COND_NONE, '0);
			4'd4: u = mk_uop(OP_MUL, SRC_X3, SRC_INV6, 1'b1, 1'b0, DST_T, COND_NONE, '0);
			4'd5: u = mk_uop(OP_MUL, SRC_X3, SRC_X1, 1'b0, 1'b0, DST_X4, COND_NONE, '0);
			4'd6: u = mk_uop(OP_MUL, SRC_X4, SRC_X1, 1'b0, 1'b0, DST_X5, COND_NONE, '0);
			4'd7: u = mk_uop(OP_POLY, SRC_X1, SRC_X1, 1'b0, 1'b0, DST_X2, COND_RAW,
				STEP_EMIT);
			4'd8: u = mk_uop(OP_MUL, SRC_RES, SRC_AMPL, 1'b0, 1'b1, DST_HI, COND_NONE, '0);
			4'd9: u = mk_uop(OP_SCALE, SRC_X1, SRC_X1, 1'b0, 1'b0, DST_X2, COND_NONE, '0);
			default: u = mk_uop(OP_EMIT, SRC_X1, SRC_X1, 1'b0, 1'b0, DST_X2, COND_END, '0);
		endcase
		return u;
	endfunction

endpackage

// File: sv/sine_table_generator_16bit.sv
// The microcode sequencer steps each accepted input beat through two phase folds,
// five multiplies on one shared 17x17 multiplier, the polynomial, in scaled mode
// one more multiply and the scale step, then the emit into the output register,
// which waits on tready. No new item is taken before the current one is emitted.
// Reset (arst_n low, asynchronous) clears the phase, returns the registers to
// their defaults and leaves the sequencer idle with no output beat pending.
module sine_table_generator_16bit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] sample (signed)
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	logic               mode_q;
	logic [31:0]        phase_step_q;
	logic signed [15:0] range_min_q;
	logic signed [15:0] range_max_q;
	logic [31:0]        phase_q;

	logic               busy_q;
	stg16_pkg::step_t   step_q;
	logic               out_valid_q;
	logic [15:0]        out_data_q;

	logic [31:0]        p_q;
	logic               neg_q;
	logic [15:0]        ampl_q;
	logic [15:0]        x2_q;
	logic [15:0]        x3_q;
	logic [15:0]        t_q;
	logic [15:0]        x4_q;
	logic [15:0]        x5_q;
	logic [15:0]        hi_q;
	logic [15:0]        res_q;

	stg16_pkg::uop_t    uop;
	logic               in_fire;
	logic               run;
	logic               stall;
	logic               jump;
	logic [31:0]        p_start;
	logic [15:0]        x1;
	logic [15:0]        op_a;
	logic [15:0]        op_b;
	logic signed [16:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [33:0] mul_prod;
	logic [15:0]        mul_hi;
	logic [15:0]        poly_mag;
	logic [15:0]        poly_u;
	logic [15:0]        half;
	logic [15:0]        scaled;

	assign s_axis_tready = !busy_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign uop   = stg16_pkg::uop_rom(step_q);
	assign stall = (uop.op == stg16_pkg::OP_EMIT) && out_valid_q && !m_axis_tready;
	assign run   = busy_q && !stall;
	assign jump  = (uop.cond == stg16_pkg::COND_RAW) && !mode_q;

	assign p_start = s_axis_tdata[0] ? 32'd0 : phase_q;
	assign x1      = {p_q[28:16], 3'b000};

	always_comb begin
		case (uop.src_a)
			stg16_pkg::SRC_X1:   op_a = x1;
			stg16_pkg::SRC_X2:   op_a = x2_q;
			stg16_pkg::SRC_X3:   op_a = x3_q;
			stg16_pkg::SRC_X4:   op_a = x4_q;
			stg16_pkg::SRC_INV6: op_a = stg16_pkg::INV6_U0F16;
			stg16_pkg::SRC_RES:  op_a = res_q;
			stg16_pkg::SRC_AMPL: op_a = ampl_q;
			default:             op_a = x1;
		endcase
		case (uop.src_b)
			stg16_pkg::SRC_X1:   op_b = x1;
			stg16_pkg::SRC_X2:   op_b = x2_q;
			stg16_pkg::SRC_X3:   op_b = x3_q;
			stg16_pkg::SRC_X4:   op_b = x4_q;
			stg16_pkg::SRC_INV6: op_b = stg16_pkg::INV6_U0F16;
			stg16_pkg::SRC_RES:  op_b = res_q;
			stg16_pkg::SRC_AMPL: op_b = ampl_q;
			default:             op_b = x1;
		endcase
	end

	assign mul_a    = $signed({uop.sgn & op_a[15], op_a});
	assign mul_b    = $signed({uop.sgn & op_b[15], op_b});
	assign mul_prod = mul_a * mul_b;
	assign mul_hi   = uop.shl ? mul_prod[30:15] : mul_prod[31:16];

	assign poly_mag = x1 - t_q + {4'b0000, x5_q[15:4]};
	assign poly_u   = neg_q ? (16'd0 - poly_mag) : poly_mag;
	assign half     = {ampl_q[15], ampl_q[15:1]};
	assign scaled   = range_min_q + half + hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			phase_step_q <= 32'd0;
			range_min_q  <= 16'sd0;
			range_max_q  <= 16'sh7FFF;
		end else if (cfg_we) begin
			case (cfg_index)
				stg16_pkg::REG_OUTPUT_MODE: mode_q       <= cfg_wdata[0];
				stg16_pkg::REG_PHASE_STEP:  phase_step_q <= cfg_wdata;
				stg16_pkg::REG_RANGE_MIN:   range_min_q  <= cfg_wdata[15:0];
				stg16_pkg::REG_RANGE_MAX:   range_max_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 32'd0;
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				phase_q <= p_start + phase_step_q;
				busy_q  <= 1'b1;
				step_q  <= '0;
			end else if (run) begin
				if (uop.cond == stg16_pkg::COND_END) begin
					busy_q <= 1'b0;
				end
				step_q <= jump ? uop.target : step_q + 1'b1;
			end
			if (run && (uop.op == stg16_pkg::OP_EMIT)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			p_q <= p_start;
		end else if (run) begin
			case (uop.op)
				stg16_pkg::OP_FOLD_PI: begin
					ampl_q <= range_max_q - range_min_q;
					if (p_q >= stg16_pkg::PHASE_PI) begin
						p_q   <= p_q - stg16_pkg::PHASE_PI;
						neg_q <= 1'b1;
					end else begin
						neg_q <= 1'b0;
					end
				end
				stg16_pkg::OP_FOLD_HALF: begin
					if (p_q >= stg16_pkg::PHASE_HALF_PI) begin
						p_q <= stg16_pkg::PHASE_PI - p_q;
					end
				end
				stg16_pkg::OP_MUL: begin
					case (uop.dst)
						stg16_pkg::DST_X2: x2_q <= mul_hi;
						stg16_pkg::DST_X3: x3_q <= mul_hi;
						stg16_pkg::DST_T:  t_q  <= mul_hi;
						stg16_pkg::DST_X4: x4_q <= mul_hi;
						stg16_pkg::DST_X5: x5_q <= mul_hi;
						stg16_pkg::DST_HI: hi_q <= mul_hi;
						default: ;
					endcase
				end
				stg16_pkg::OP_POLY:  res_q      <= poly_u;
				stg16_pkg::OP_SCALE: res_q      <= scaled;
				stg16_pkg::OP_EMIT:  out_data_q <= res_q;
				default: ;
			endcase
		end
	end

endmodule

// File: sv/stg16_checker.sv
`include "sine_table_generator_16bit_defines.svh"

module stg16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	logic in_beat;
	logic out_stall;

	assign in_beat   = s_axis_tvalid && s_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	`STG16_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid, "output beat dropped while stalled")
	`STG16_ASSERT_NEXT(a_out_stable, clk, arst_n, out_stall, $stable(m_axis_tdata), "stalled output data changed")
	`STG16_ASSERT_NEXT(a_one_item, clk, arst_n, in_beat, !s_axis_tready, "second item taken while one is in work")
	`STG16_ASSERT_NEXT(a_no_early_out, clk, arst_n, in_beat, !$rose(m_axis_tvalid), "output beat before the sample could be computed")

endmodule

bind sine_table_generator_16bit stg16_checker u_stg16_checker (.*);
